FILE: hw/rtl/ilc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilc_pkg: integer literal classifier shared definitions
// Class codes, recognizer state encodings, transition functions and the
// record that carries one classified result from the front into the queue.
// ----------------------------------------------------------------------------
package ilc_pkg;

  typedef enum logic [1:0] {
    LitNone = 2'd0,
    LitHex  = 2'd1,
    LitOct  = 2'd2,
    LitDec  = 2'd3
  } literal_class_e;

  // Dead states of the three recognizers
  localparam logic [2:0] HexDead = 3'd5;
  localparam logic [2:0] OctDead = 3'd4;
  localparam logic [3:0] DecDead = 4'd9;

  // Hex columns: leading zero, x/X, hex digit, l/L
  localparam logic [1:0] HexColZero  = 2'd0;
  localparam logic [1:0] HexColX     = 2'd1;
  localparam logic [1:0] HexColDigit = 2'd2;
  localparam logic [1:0] HexColL     = 2'd3;

  // Octal columns: leading zero, octal digit, l/L
  localparam logic [1:0] OctColZero  = 2'd0;
  localparam logic [1:0] OctColDigit = 2'd1;
  localparam logic [1:0] OctColL     = 2'd2;

  // Decimal columns: - + digit l L U u
  localparam logic [2:0] DecColMinus = 3'd0;
  localparam logic [2:0] DecColPlus  = 3'd1;
  localparam logic [2:0] DecColDigit = 3'd2;
  localparam logic [2:0] DecColLowL  = 3'd3;
  localparam logic [2:0] DecColUpL   = 3'd4;
  localparam logic [2:0] DecColUpU   = 3'd5;
  localparam logic [2:0] DecColLowU  = 3'd6;

  // Result handed from the front to the queue
  typedef struct packed {
    logic           push;
    literal_class_e lit_class;
  } ilc_result_t;

  function automatic logic [2:0] hex_next(input logic [2:0] st, input logic [1:0] col);
    logic [2:0] nxt;
    nxt = HexDead;
    case (st)
      3'd0: if (col == HexColZero) nxt = 3'd1;
      3'd1: if (col == HexColX) nxt = 3'd2;
      3'd2: if (col == HexColDigit) nxt = 3'd3;
      3'd3: begin
        if (col == HexColDigit) nxt = 3'd3;
        else if (col == HexColL) nxt = 3'd4;
      end
      default: nxt = HexDead;
    endcase
    return nxt;
  endfunction

  function automatic logic [2:0] oct_next(input logic [2:0] st, input logic [1:0] col);
    logic [2:0] nxt;
    nxt = OctDead;
    case (st)
      3'd0: if (col == OctColZero) nxt = 3'd1;
      3'd1: if (col == OctColDigit) nxt = 3'd2;
      3'd2: begin
        if (col == OctColDigit) nxt = 3'd2;
        else if (col == OctColL) nxt = 3'd3;
      end
      default: nxt = OctDead;
    endcase
    return nxt;
  endfunction

  function automatic logic [3:0] dec_next(input logic [3:0] st, input logic [2:0] col);
    logic [3:0] nxt;
    nxt = DecDead;
    case (st)
      4'd0: begin
        if (col == DecColMinus || col == DecColPlus) nxt = 4'd1;
        else if (col == DecColDigit) nxt = 4'd3;
      end
      4'd1: if (col == DecColDigit) nxt = 4'd2;
      4'd2: begin
        if (col == DecColDigit) nxt = 4'd2;
        else if (col == DecColLowL || col == DecColUpL) nxt = 4'd4;
      end
      4'd3: begin
        if (col == DecColDigit) nxt = 4'd3;
        else if (col == DecColLowL || col == DecColUpL) nxt = 4'd5;
        else if (col == DecColUpU || col == DecColLowU) nxt = 4'd6;
      end
      4'd5: if (col == DecColUpU || col == DecColLowU) nxt = 4'd7;
      4'd6: if (col == DecColLowL || col == DecColUpL) nxt = 4'd8;
      default: nxt = DecDead;
    endcase
    return nxt;
  endfunction

endpackage

FILE: hw/rtl/ilc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilc_front: recognizer front end
// Advances the hex, octal and decimal recognizers by one byte per accepted
// transaction and classifies the string on its last byte.
// ----------------------------------------------------------------------------
module ilc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          character_i,
  input  logic                last_char_i,
  output ilc_pkg::ilc_result_t result_o
);

  logic [2:0] hex_st_q, hex_st_d;
  logic [2:0] oct_st_q, oct_st_d;
  logic [3:0] dec_st_q, dec_st_d;
  logic [2:0] alpha_ok_q, alpha_ok_d;
  logic [1:0] pos_q, pos_d;
  logic       first_zero_q, first_zero_d;
  logic       first_sign_q, first_sign_d;
  logic       second_zero_q, second_zero_d;
  logic [1:0] reject_q, reject_d;

  logic       is_zero, is_l, is_x, is_u, is_sign, is_dec, is_hex, is_oct;
  logic [2:0] hex_cur, oct_cur;
  logic [3:0] dec_cur;
  logic [1:0] hex_col;
  logic [2:0] dec_col;
  ilc_pkg::literal_class_e lit_class;

  always_comb begin
    is_zero = (character_i == 8'h30);
    is_l    = (character_i == 8'h6c) || (character_i == 8'h4c);
    is_x    = (character_i == 8'h78) || (character_i == 8'h58);
    is_u    = (character_i == 8'h75) || (character_i == 8'h55);
    is_sign = (character_i == 8'h2b) || (character_i == 8'h2d);
    is_dec  = (character_i >= 8'h30) && (character_i <= 8'h39);
    is_oct  = (character_i >= 8'h30) && (character_i <= 8'h37);
    is_hex  = is_dec || ((character_i >= 8'h61) && (character_i <= 8'h66))
              || ((character_i >= 8'h41) && (character_i <= 8'h46));

    hex_cur = (hex_st_q > ilc_pkg::HexDead) ? ilc_pkg::HexDead : hex_st_q;
    oct_cur = (oct_st_q > ilc_pkg::OctDead) ? ilc_pkg::OctDead : oct_st_q;
    dec_cur = (dec_st_q > ilc_pkg::DecDead) ? ilc_pkg::DecDead : dec_st_q;

    case (character_i)
      8'h2d:   dec_col = ilc_pkg::DecColMinus;
      8'h2b:   dec_col = ilc_pkg::DecColPlus;
      8'h6c:   dec_col = ilc_pkg::DecColLowL;
      8'h4c:   dec_col = ilc_pkg::DecColUpL;
      8'h55:   dec_col = ilc_pkg::DecColUpU;
      8'h75:   dec_col = ilc_pkg::DecColLowU;
      default: dec_col = ilc_pkg::DecColDigit;
    endcase
    hex_col = is_x ? ilc_pkg::HexColX : (is_l ? ilc_pkg::HexColL : ilc_pkg::HexColDigit);

    // Drop alphabet flags on any foreign byte
    alpha_ok_d    = alpha_ok_q;
    if (!(is_hex || is_x || is_l)) alpha_ok_d[0] = 1'b0;
    if (!(is_oct || is_l)) alpha_ok_d[1] = 1'b0;
    if (!(is_dec || is_sign || is_l || is_u)) alpha_ok_d[2] = 1'b0;

    // Leading-zero rules
    reject_d = reject_q;
    if (pos_q == 2'd1 && first_zero_q) reject_d[1] = 1'b1;
    if (pos_q == 2'd2 && second_zero_q && first_sign_q) reject_d[1] = 1'b1;
    if (pos_q == 2'd2 && is_zero && second_zero_q) reject_d[0] = 1'b1;

    first_zero_d  = first_zero_q;
    first_sign_d  = first_sign_q;
    second_zero_d = second_zero_q;
    if (pos_q == 2'd0) begin
      hex_st_d     = is_zero ? ilc_pkg::hex_next(hex_cur, ilc_pkg::HexColZero)
                             : ilc_pkg::HexDead;
      oct_st_d     = is_zero ? ilc_pkg::oct_next(oct_cur, ilc_pkg::OctColZero)
                             : ilc_pkg::OctDead;
      first_zero_d = is_zero;
      first_sign_d = is_sign;
    end else begin
      hex_st_d = ilc_pkg::hex_next(hex_cur, hex_col);
      oct_st_d = ilc_pkg::oct_next(oct_cur, is_l ? ilc_pkg::OctColL : ilc_pkg::OctColDigit);
      if (pos_q == 2'd1) second_zero_d = is_zero;
    end
    dec_st_d = ilc_pkg::dec_next(dec_cur, dec_col);
    pos_d    = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;

    // Priority: hex, octal, decimal
    if (alpha_ok_d[0] && (hex_st_d == 3'd3 || hex_st_d == 3'd4)) begin
      lit_class = ilc_pkg::LitHex;
    end else if (alpha_ok_d[1] && !reject_d[0] && (oct_st_d == 3'd2 || oct_st_d == 3'd3)) begin
      lit_class = ilc_pkg::LitOct;
    end else if (alpha_ok_d[2] && !reject_d[1] && dec_st_d >= 4'd2 && dec_st_d <= 4'd8) begin
      lit_class = ilc_pkg::LitDec;
    end else begin
      lit_class = ilc_pkg::LitNone;
    end
  end

  assign result_o.push      = accept_i && last_char_i;
  assign result_o.lit_class = lit_class;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_st_q      <= 3'd0;
      oct_st_q      <= 3'd0;
      dec_st_q      <= 4'd0;
      alpha_ok_q    <= 3'b111;
      pos_q         <= 2'd0;
      first_zero_q  <= 1'b0;
      first_sign_q  <= 1'b0;
      second_zero_q <= 1'b0;
      reject_q      <= 2'b00;
    end else if (accept_i && last_char_i) begin
      hex_st_q      <= 3'd0;
      oct_st_q      <= 3'd0;
      dec_st_q      <= 4'd0;
      alpha_ok_q    <= 3'b111;
      pos_q         <= 2'd0;
      first_zero_q  <= 1'b0;
      first_sign_q  <= 1'b0;
      second_zero_q <= 1'b0;
      reject_q      <= 2'b00;
    end else if (accept_i) begin
      hex_st_q      <= hex_st_d;
      oct_st_q      <= oct_st_d;
      dec_st_q      <= dec_st_d;
      alpha_ok_q    <= alpha_ok_d;
      pos_q         <= pos_d;
      first_zero_q  <= first_zero_d;
      first_sign_q  <= first_sign_d;
      second_zero_q <= second_zero_d;
      reject_q      <= reject_d;
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_char_i) |=> (pos_q == 2'd0 && alpha_ok_q == 3'b111 && reject_q == 2'b00))
    else $error("front did not restart after last byte");

  a_dead_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !last_char_i && pos_q != 2'd0 && hex_st_q == ilc_pkg::HexDead)
    |=> (hex_st_q == ilc_pkg::HexDead))
    else $error("hex recognizer left its dead state");

endmodule

FILE: hw/rtl/ilc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilc_queue: result queue
// Holds classified results between the front end and the output channel so
// each side can stall on its own.
// ----------------------------------------------------------------------------
module ilc_queue #(
  parameter int Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ilc_pkg::ilc_result_t    result_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output ilc_pkg::literal_class_e literal_class_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ilc_pkg::literal_class_e mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign full_o          = (count_q == CntFull);
  assign out_valid_o     = (count_q != '0);
  assign literal_class_o = mem_q[rd_ptr_q];
  assign push            = result_i.push && !full_o;
  assign pop             = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= result_i.lit_class;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      case ({push, pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count exceeds depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_i.push |-> !full_o)
    else $error("result pushed into a full queue");

endmodule

FILE: hw/rtl/integer_literal_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_classifier_top: integer literal classifier
// Classifies a byte string as a hex, octal or decimal integer constant.
// ----------------------------------------------------------------------------
// Feed one byte per input transaction, with last_char_i high on the final
// byte of each string. The front end steps the hex, octal and decimal
// recognizers and their alphabet and leading-zero checks together on each
// byte, so a new byte is taken every cycle unless input stalls. On the
// last byte one result transaction (class 0 none, 1 hex, 2 octal, 3 decimal,
// hex winning over octal over decimal) enters a QUEUE_DEPTH-entry queue and
// is offered on the output channel from the next cycle on; the recognizers
// restart for the next string at once. Input stalls only while that queue is
// full, which takes QUEUE_DEPTH strings left unread at the output.
// ----------------------------------------------------------------------------
module integer_literal_classifier_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] character_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] literal_class_o
);

  ilc_pkg::ilc_result_t    result;
  ilc_pkg::literal_class_e lit_class;
  logic                    queue_full;
  logic                    in_accept;

  // Hold input while no queue slot is free for a possible result
  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  ilc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .result_o    (result)
  );

  ilc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .result_i        (result),
    .full_o          (queue_full),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .literal_class_o (lit_class)
  );

  assign literal_class_o = lit_class;

  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_char_i) |=> out_valid_o)
    else $error("classified string produced no output");

endmodule
